[rtl/esmd_pkg.sv]
// Shared types, constants and the CRC-16 step for the escape-stuffed deframer.
// No dependencies.
`default_nettype none
package esmd_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);

  localparam logic [7:0]  ESC_BYTE      = 8'd254;
  localparam logic [7:0]  ESC_LITERAL   = 8'd0;
  localparam logic [7:0]  ESC_SEPARATOR = 8'd1;
  localparam logic [15:0] CRC_POLY      = 16'h1021;

  localparam logic REG_CRC_CHECK    = 1'b0;
  localparam logic REG_LENGTH_LIMIT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic wr;
    logic wr_esc;
    logic clr;
    logic start;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic crc_zero;
    logic len_gt0;
    logic len_gt2;
    logic issue_ok;
    logic issue_last;
  } status_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else       c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/esmd_ctrl.sv]
// Controller: escape decode, message open/abort/close and replay sequencing.
// Depends on esmd_pkg.
`default_nettype none
module esmd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              crc_check,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  esmd_pkg::status_t status,
  output esmd_pkg::cmd_t    cmd
);

  esmd_pkg::state_t state, state_next;
  logic escape_pending, escape_pending_next;
  logic in_message, in_message_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= esmd_pkg::ST_IDLE;
      escape_pending <= 1'b0;
      in_message     <= 1'b0;
    end else begin
      state          <= state_next;
      escape_pending <= escape_pending_next;
      in_message     <= in_message_next;
    end
  end

  always_comb begin
    logic take;
    logic close;
    logic ok;
    state_next          = state;
    escape_pending_next = escape_pending;
    in_message_next     = in_message;
    cmd                 = '0;
    in_stall            = 1'b1;
    take                = 1'b0;
    close               = 1'b0;
    ok                  = 1'b0;
    unique case (state)
      esmd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            if (rx_byte == esmd_pkg::ESC_LITERAL) begin
              take       = 1'b1;
              cmd.wr_esc = 1'b1;
            end else if (rx_byte == esmd_pkg::ESC_SEPARATOR) begin
              close = 1'b1;
            end else begin
              in_message_next = 1'b0;
              cmd.clr         = 1'b1;
            end
          end else if (rx_byte == esmd_pkg::ESC_BYTE) begin
            escape_pending_next = 1'b1;
          end else begin
            take = 1'b1;
          end
          if (take && in_message) begin
            if (status.full) begin
              in_message_next = 1'b0;
              cmd.clr         = 1'b1;
            end else begin
              cmd.wr = 1'b1;
            end
          end
          if (close) begin
            ok = in_message && (crc_check ? (status.len_gt2 && status.crc_zero)
                                          : status.len_gt0);
            in_message_next = 1'b1;
            cmd.clr         = 1'b1;
            if (ok) begin
              cmd.start  = 1'b1;
              state_next = esmd_pkg::ST_EMIT;
            end
          end
        end
      end
      esmd_pkg::ST_EMIT: begin
        cmd.issue = status.issue_ok;
        if (status.issue_ok && status.issue_last) state_next = esmd_pkg::ST_IDLE;
      end
      default: state_next = esmd_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/esmd_datapath.sv]
// Datapath: message store, byte count, running CRC, replay read and output register.
// Depends on esmd_pkg.
`default_nettype none
module esmd_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              crc_check,
  input  logic [6:0]        length_limit,
  input  logic [7:0]        rx_byte,
  input  esmd_pkg::cmd_t    cmd,
  output esmd_pkg::status_t status,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        payload_byte,
  output logic              end_of_message
);

  logic [7:0]              store [esmd_pkg::BUF_DEPTH];
  logic [esmd_pkg::CW-1:0] stored_count;
  logic [15:0]             running_crc;
  logic [esmd_pkg::CW-1:0] emit_len;
  logic [esmd_pkg::CW-1:0] rd_cnt;
  logic [7:0]              rd_data;
  logic                    rd_last;
  logic                    rd_valid;
  logic [esmd_pkg::CW-1:0] lim;
  logic [7:0]              wr_byte;
  logic                    last_hit;
  logic                    move;

  assign lim = (length_limit > 7'(esmd_pkg::BUF_DEPTH)) ? esmd_pkg::CW'(esmd_pkg::BUF_DEPTH)
                                                        : length_limit[esmd_pkg::CW-1:0];
  assign wr_byte  = cmd.wr_esc ? esmd_pkg::ESC_BYTE : rx_byte;
  assign last_hit = (rd_cnt + esmd_pkg::CW'(1)) == emit_len;
  assign move     = rd_valid && (!out_valid || !out_stall);

  assign status.full       = stored_count >= lim;
  assign status.crc_zero   = running_crc == 16'h0000;
  assign status.len_gt0    = stored_count != '0;
  assign status.len_gt2    = stored_count > esmd_pkg::CW'(2);
  assign status.issue_ok   = !rd_valid || move;
  assign status.issue_last = last_hit;

  always_ff @(posedge clk) begin
    if (cmd.wr) store[stored_count[esmd_pkg::AW-1:0]] <= wr_byte;
    if (cmd.issue) begin
      rd_data <= store[rd_cnt[esmd_pkg::AW-1:0]];
      rd_last <= last_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      running_crc  <= '0;
    end else if (cmd.clr) begin
      stored_count <= '0;
      running_crc  <= '0;
    end else if (cmd.wr) begin
      stored_count <= stored_count + esmd_pkg::CW'(1);
      running_crc  <= esmd_pkg::crc16_update(running_crc, wr_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      emit_len <= crc_check ? stored_count - esmd_pkg::CW'(2) : stored_count;
      rd_cnt   <= '0;
    end else if (cmd.issue) begin
      rd_cnt <= rd_cnt + esmd_pkg::CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.issue)  rd_valid <= 1'b1;
      else if (move)  rd_valid <= 1'b0;
      if (move)            out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      payload_byte   <= rd_data;
      end_of_message <= rd_last;
    end
  end

endmodule
`default_nettype wire

[rtl/escape_stuffed_message_deframer.sv]
// Escape-stuffed message deframer with CRC-16 check: top level and APB registers.
// Depends on esmd_pkg, esmd_ctrl, esmd_datapath.
//
// Takes one link byte per cycle while no message is being replayed. A separator
// that closes an accepted message holds in_stall high while its payload bytes
// are read back from the store through its single read port, one byte per cycle
// unless out_stall holds the output, through a read register and an output
// register; the next byte is taken as soon as the last read is issued.
// Registers: crc_check at 0x0 (reset 1), length_limit at 0x4 (reset 64).
`default_nettype none
module escape_stuffed_message_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  payload_byte,
  output logic        end_of_message
);

  logic              crc_check;
  logic [6:0]        length_limit;
  esmd_pkg::cmd_t    cmd;
  esmd_pkg::status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_check    <= 1'b1;
      length_limit <= 7'd64;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        esmd_pkg::REG_CRC_CHECK:    crc_check    <= pwdata[0];
        esmd_pkg::REG_LENGTH_LIMIT: length_limit <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      esmd_pkg::REG_CRC_CHECK:    prdata = {31'd0, crc_check};
      esmd_pkg::REG_LENGTH_LIMIT: prdata = {25'd0, length_limit};
      default:                    prdata = '0;
    endcase
  end

  esmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .crc_check (crc_check),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .status    (status),
    .cmd       (cmd)
  );

  esmd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .crc_check      (crc_check),
    .length_limit   (length_limit),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .payload_byte   (payload_byte),
    .end_of_message (end_of_message)
  );

endmodule
`default_nettype wire

[rtl/esmd_checker.sv]
// Port-level checker for the deframer, bound to the top level.
// Depends on escape_stuffed_message_deframer.
`default_nettype none
module esmd_checker (
  input logic       clk,
  input logic       rst,
  input logic       pready,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] payload_byte,
  input logic       end_of_message
);

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled straight after reset");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(end_of_message))
    else $error("stalled output word changed");

endmodule

bind escape_stuffed_message_deframer esmd_checker u_esmd_checker (
  .clk            (clk),
  .rst            (rst),
  .pready         (pready),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .payload_byte   (payload_byte),
  .end_of_message (end_of_message)
);
`default_nettype wire

[tb/tb.sv]
// Testbench for escape_stuffed_message_deframer: escaped link bytes in, accepted payload words out.
// Holds its own deframer and CRC-16 predictor and checks each output word in order.
// Depends on esmd_pkg and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] ADDR_CRC_CHECK = {esmd_pkg::REG_CRC_CHECK, 2'b00};
  localparam logic [2:0] ADDR_LENGTH_LIMIT = {esmd_pkg::REG_LENGTH_LIMIT, 2'b00};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  payload_byte;
  logic        end_of_message;

  // predictor state
  logic        cfg_crc = 1'b1;
  logic [6:0]  cfg_limit = 7'd64;
  logic        esc_seen = 1'b0;
  logic        msg_open = 1'b0;
  logic [6:0]  held_count = '0;
  logic [15:0] crc_acc = '0;
  logic [7:0]  held[esmd_pkg::BUF_DEPTH];

  out_word_t expected_words[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  words_sent = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  calm = 1'b0;

  escape_stuffed_message_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .payload_byte   (payload_byte),
    .end_of_message (end_of_message)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // bitwise CRC-16, poly 0x1021, MSB first
  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? esmd_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void store_byte(logic [7:0] b);
    logic [6:0] lim;
    lim = (cfg_limit > esmd_pkg::BUF_DEPTH) ? 7'(esmd_pkg::BUF_DEPTH) : cfg_limit;
    if (msg_open) begin
      if (held_count >= lim) begin
        msg_open = 1'b0;
        held_count = '0;
        crc_acc = '0;
      end else begin
        held[held_count[esmd_pkg::AW-1:0]] = b;
        held_count++;
        crc_acc = crc_step(crc_acc, b);
      end
    end
  endfunction

  function automatic void predict_deframe(logic [7:0] b);
    int   len;
    logic ok;
    if (esc_seen) begin
      esc_seen = 1'b0;
      if (b == esmd_pkg::ESC_LITERAL) begin
        store_byte(esmd_pkg::ESC_BYTE);
      end else if (b == esmd_pkg::ESC_SEPARATOR) begin
        len = held_count;
        ok = msg_open;
        if (ok && cfg_crc) begin
          if (len <= 2 || crc_acc != 0) ok = 1'b0;
          else len -= 2;
        end
        if (ok) begin
          for (int k = 0; k < len; k++)
            expected_words.push_back(out_word_t'{data: held[k], last: 1'(k == len - 1)});
        end
        msg_open = 1'b1;
        held_count = '0;
        crc_acc = '0;
      end else begin
        msg_open = 1'b0;
        held_count = '0;
        crc_acc = '0;
      end
    end else if (b == esmd_pkg::ESC_BYTE) begin
      esc_seen = 1'b1;
    end else begin
      store_byte(b);
    end
  endfunction

  always @(posedge clk) begin : watch_ports
    out_word_t want;
    if (!rst) begin
      if (in_valid && !in_stall) predict_deframe(rx_byte);
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          note_failure($sformatf("unexpected word: byte %02h last %0b",
                                 payload_byte, end_of_message));
        end else begin
          want = expected_words.pop_front();
          if (want.data !== payload_byte || want.last !== end_of_message)
            note_failure($sformatf(
              "mismatch: expected byte %02h last %0b, got byte %02h last %0b",
              want.data, want.last, payload_byte, end_of_message));
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_stuffed(input logic [7:0] b);
    if (b == esmd_pkg::ESC_BYTE) begin
      send_word(esmd_pkg::ESC_BYTE);
      send_word(esmd_pkg::ESC_LITERAL);
    end else begin
      send_word(b);
    end
  endtask

  task automatic send_separator();
    send_word(esmd_pkg::ESC_BYTE);
    send_word(esmd_pkg::ESC_SEPARATOR);
  endtask

  task automatic send_frame(input byte_q_t body, input bit add_crc, input bit corrupt,
                            input bit close);
    logic [15:0] c;
    c = '0;
    foreach (body[i]) begin
      c = crc_step(c, body[i]);
      send_stuffed(body[i]);
    end
    if (add_crc) begin
      if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
      send_stuffed(c[15:8]);
      send_stuffed(c[7:0]);
    end
    if (close) send_separator();
  endtask

  function automatic logic [7:0] random_link_byte();
    return ($urandom_range(0, 7) == 0) ? esmd_pkg::ESC_BYTE : 8'($urandom_range(0, 255));
  endfunction

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] want;
    settle();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_CRC_CHECK) cfg_crc = value[0];
    else cfg_limit = value[6:0];
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (addr == ADDR_CRC_CHECK) ? 32'(cfg_crc) : 32'(cfg_limit);
    if (prdata !== want)
      note_failure($sformatf("register %0h: expected %0h, read %0h", addr, want, prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_traffic(input int target);
    byte_q_t body;
    int      start, eff, room, kind, n;
    start = words_sent;
    while (words_sent < start + target) begin
      eff = (cfg_limit > esmd_pkg::BUF_DEPTH) ? esmd_pkg::BUF_DEPTH : cfg_limit;
      room = cfg_crc ? eff - 2 : eff;
      kind = $urandom_range(0, 99);
      body.delete();
      if (kind < 70) begin
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(0, room)
                                        : $urandom_range(0, (room < 12) ? room : 12);
        repeat (n) body.push_back(random_link_byte());
        send_frame(body, cfg_crc, cfg_crc && $urandom_range(0, 9) == 0, 1'b1);
      end else if (kind < 80) begin
        // overrun the length limit
        n = eff + $urandom_range(1, 3);
        repeat (n) body.push_back(random_link_byte());
        send_frame(body, 1'b0, 1'b0, 1'b1);
      end else if (kind < 90) begin
        // cut short by an unknown escape code
        n = $urandom_range(0, 4);
        repeat (n) body.push_back(random_link_byte());
        send_frame(body, 1'b0, 1'b0, 1'b0);
        send_word(esmd_pkg::ESC_BYTE);
        send_word(8'($urandom_range(2, 255)));
        send_separator();
      end else begin
        repeat ($urandom_range(1, 4)) send_word(random_link_byte());
      end
    end
  endtask

  task automatic test_directed_framing();
    byte_q_t body;
    send_separator();                       // no open message yet
    body = '{8'h00, esmd_pkg::ESC_BYTE, 8'hff};
    send_frame(body, 1'b1, 1'b0, 1'b1);
    body = '{8'h55};
    send_frame(body, 1'b1, 1'b1, 1'b1);     // bad CRC
    send_word(8'h12);
    send_word(esmd_pkg::ESC_BYTE);
    send_word(8'h07);                       // unknown code aborts
    send_word(8'h33);                       // ignored while closed
    send_separator();
    send_word(esmd_pkg::ESC_BYTE);
    send_word(esmd_pkg::ESC_BYTE);          // escape after escape aborts
    send_separator();
  endtask

  task automatic test_limits_and_modes();
    byte_q_t body;
    set_register(ADDR_CRC_CHECK, 32'd0);
    set_register(ADDR_LENGTH_LIMIT, 32'd3);
    body = '{8'h01, 8'h02, 8'h03};
    send_frame(body, 1'b0, 1'b0, 1'b1);     // exactly at the limit
    body = '{8'h04, 8'h05, 8'h06, 8'h07};
    send_frame(body, 1'b0, 1'b0, 1'b1);     // overflow
    send_separator();                       // empty message
    set_register(ADDR_CRC_CHECK, 32'd1);
    body.delete();
    send_frame(body, 1'b1, 1'b0, 1'b1);     // CRC only, too short
    body = '{8'h9c};
    send_frame(body, 1'b1, 1'b0, 1'b0);
    set_register(ADDR_CRC_CHECK, 32'd0);    // mode changed mid-message
    send_separator();
  endtask

  task automatic test_backpressure();
    byte_q_t body;
    set_register(ADDR_CRC_CHECK, 32'd1);
    set_register(ADDR_LENGTH_LIMIT, 32'd64);
    hold_req = 1'b1;
    repeat (3) begin
      body.delete();
      repeat (20) body.push_back(random_link_byte());
      send_frame(body, 1'b1, 1'b0, 1'b1);
    end
  endtask

  task automatic test_random_phases();
    bit         crc_sel[6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [6:0] lim_sel[6];
    lim_sel = '{7'd64, 7'd64, 7'd3, 7'd3, 7'($urandom_range(4, 63)), 7'($urandom_range(4, 63))};
    for (int p = 0; p < 6; p++) begin
      set_register(ADDR_CRC_CHECK, 32'(crc_sel[p]));
      set_register(ADDR_LENGTH_LIMIT, 32'(lim_sel[p]));
      random_traffic(35);
    end
  endtask

  task automatic test_quiet_tail();
    set_register(ADDR_CRC_CHECK, 32'd1);
    set_register(ADDR_LENGTH_LIMIT, 32'd64);
    calm = 1'b1;
    random_traffic(35);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_framing();
    test_limits_and_modes();
    test_backpressure();
    test_random_phases();
    test_quiet_tail();
    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
